>>> src/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define FGB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define FGB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/fgb_pkg.sv
// ----------------------------------------------------------------------------
// fgb_pkg
// Shared types, constants and exponent tables of the fuzzy Gaussian
// background pixel block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fgb_pkg;

    localparam int NUM_PIXELS_DEF = 131072;

    localparam int IDX_W   = 17;
    localparam int PX_W    = 8;
    localparam int MEAN_W  = 16;
    localparam int VAR_W   = 21;
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DIST_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FG_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_EXP   = 3'd4;

    localparam logic [14:0] DIST_THR_RST  = 15'd3136;
    localparam logic [16:0] FG_LEVEL_RST  = 17'd32768;
    localparam logic [16:0] ALPHA_MAX_RST = 17'd1311;
    localparam logic [11:0] NOISE_RST     = 12'd1600;
    localparam logic signed [15:0] RATE_EXP_RST = -16'sd20480;

    // Variance of every entry after reset.
    localparam logic [VAR_W-1:0] VAR_RESET = 21'd1600;

    // Datapath stage positions; stage 0 is the memory read stage.
    localparam int DIV_FIRST = 2;
    localparam int DIV_LAST  = 25;
    localparam int ST_SUM    = 26;
    localparam int FZ_FIRST  = 27;
    localparam int FZ_LAST   = 42;
    localparam int ST_RATE   = 43;
    localparam int ST_FRAC   = 44;
    localparam int ST_EXP    = 45;
    localparam int ST_ALPHA  = 46;
    localparam int ST_MINC   = 47;
    localparam int ST_MEAN   = 48;
    localparam int ST_SQ     = 49;
    localparam int ST_VINC   = 50;
    localparam int ST_VAR    = 51;
    localparam int LAT       = 51;

    typedef struct packed {
        logic [14:0]        dist_thr;
        logic [16:0]        fg_level;
        logic [16:0]        alpha_max;
        logic [11:0]        noise_floor;
        logic signed [15:0] rate_exp;
    } cfg_t;

    typedef struct packed {
        logic                   init;
        logic [IDX_W-1:0]       idx;
        logic [2:0][PX_W-1:0]   px;
    } pipe_t;

    typedef struct packed {
        logic [2:0][PX_W-1:0]   px;
        logic [2:0][MEAN_W-1:0] mean;
        logic [2:0][VAR_W-1:0]  vari;
        logic [2:0]             dneg;
        logic [2:0][MEAN_W-1:0] dmag;
    } carry_t;

    // exp(-n) for whole steps of the exponent, 1.16 fixed point.
    function automatic logic [16:0] exp_int(input logic [3:0] n);
        logic [16:0] r;
        case (n)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd24109;
            4'd2:    r = 17'd8869;
            4'd3:    r = 17'd3263;
            4'd4:    r = 17'd1200;
            4'd5:    r = 17'd442;
            4'd6:    r = 17'd162;
            4'd7:    r = 17'd60;
            default: r = 17'd22;
        endcase
        return r;
    endfunction

    // exp(-i/16) for the sixteenths of one step, 1.16 fixed point.
    function automatic logic [16:0] exp_frac(input logic [4:0] i);
        logic [16:0] r;
        case (i)
            5'd0:    r = 17'd65536;
            5'd1:    r = 17'd61565;
            5'd2:    r = 17'd57835;
            5'd3:    r = 17'd54331;
            5'd4:    r = 17'd51039;
            5'd5:    r = 17'd47947;
            5'd6:    r = 17'd45042;
            5'd7:    r = 17'd42313;
            5'd8:    r = 17'd39750;
            5'd9:    r = 17'd37341;
            5'd10:   r = 17'd35079;
            5'd11:   r = 17'd32954;
            5'd12:   r = 17'd30957;
            5'd13:   r = 17'd29081;
            5'd14:   r = 17'd27319;
            5'd15:   r = 17'd25664;
            default: r = 17'd24109;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/fgb_datapath.sv
// ----------------------------------------------------------------------------
// fgb_datapath
// Pipelined model update: distance, two restoring dividers, learning rate,
// mean and variance update. Advances as a whole when adv is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fgb_datapath (
    input  wire logic                  aclk,
    input  wire logic                  adv,
    input  wire fgb_pkg::cfg_t         cfg,
    input  wire logic [2:0][7:0]       in_px,
    input  wire logic [2:0][15:0]      in_mean,
    input  wire logic [2:0][20:0]      in_var,
    output logic [2:0][15:0]           out_mean,
    output logic [2:0][20:0]           out_var,
    output logic                       out_fg
);

    localparam int DF = fgb_pkg::DIV_FIRST;
    localparam int DL = fgb_pkg::DIV_LAST;
    localparam int FF = fgb_pkg::FZ_FIRST;
    localparam int FL = fgb_pkg::FZ_LAST;
    localparam int LAT = fgb_pkg::LAT;

    // Stage 1
    fgb_pkg::carry_t   s0_carry;
    logic [2:0][31:0]  sq1_next;
    logic [2:0][20:0]  v1_next;
    logic [2:0][31:0]  sq1_reg;
    logic [2:0][20:0]  v1_reg;
    fgb_pkg::carry_t   cr_reg [1:LAT];

    // Distance divider
    logic [2:0][20:0]  dv_rem_in  [DF:DL];
    logic [2:0][23:0]  dv_quo_in  [DF:DL];
    logic [2:0][23:0]  dv_low_in  [DF:DL];
    logic [2:0][20:0]  dv_v_in    [DF:DL];
    logic [2:0]        dv_sat_in  [DF:DL];
    logic [2:0][20:0]  dv_rem_next [DF:DL];
    logic [2:0][23:0]  dv_quo_next [DF:DL];
    logic [2:0][20:0]  dv_rem_reg [DF:DL];
    logic [2:0][23:0]  dv_quo_reg [DF:DL];
    logic [2:0][23:0]  dv_low_reg [DF:DL];
    logic [2:0][20:0]  dv_v_reg   [DF:DL];
    logic [2:0]        dv_sat_reg [DF:DL];

    logic [26:0]       sum_next;
    logic [26:0]       sum_reg;

    // Fuzzy level divider
    logic [14:0]       fz_rem_in  [FF:FL];
    logic [15:0]       fz_quo_in  [FF:FL];
    logic [15:0]       fz_low_in  [FF:FL];
    logic              fz_sat_in  [FF:FL];
    logic [14:0]       fz_rem_next [FF:FL];
    logic [15:0]       fz_quo_next [FF:FL];
    logic [14:0]       fz_rem_reg [FF:FL];
    logic [15:0]       fz_quo_reg [FF:FL];
    logic [15:0]       fz_low_reg [FF:FL];
    logic              fz_sat_reg [FF:FL];

    // Learning rate
    logic [16:0]       fuzzy_w;
    logic [15:0]       nre_w;
    logic [32:0]       mprod_w;
    logic              fg_next;
    logic [15:0]       m_next;
    logic [15:0]       m_reg;
    logic [16:0]       fa_w;
    logic [16:0]       fb_w;
    logic [16:0]       fdlt_w;
    logic [19:0]       fprod_w;
    logic [16:0]       ef_next;
    logic [16:0]       ei_next;
    logic [16:0]       ef_reg;
    logic [16:0]       ei_reg;
    logic [33:0]       eprod_w;
    logic [16:0]       e_reg;
    logic [33:0]       aprod_w;
    logic [16:0]       alpha_next;
    logic              fg_reg [fgb_pkg::ST_RATE:LAT];
    logic [16:0]       al_reg [fgb_pkg::ST_ALPHA:fgb_pkg::ST_SQ];

    // Mean and variance update
    logic [2:0][32:0]  iprod_w;
    logic [2:0][15:0]  inc_reg;
    logic [2:0][17:0]  mu18_w;
    logic [2:0][15:0]  mu_next;
    logic [2:0][15:0]  mu_reg [fgb_pkg::ST_MEAN:LAT];
    logic [2:0][16:0]  r17_w;
    logic [2:0][16:0]  rneg_w;
    logic [2:0][15:0]  rm_w;
    logic [2:0][31:0]  rsq_w;
    logic [2:0][20:0]  sq_reg;
    logic [2:0][21:0]  vd_w;
    logic [2:0][21:0]  vdn_w;
    logic [2:0][20:0]  vmag_w;
    logic [2:0][37:0]  vprod_w;
    logic [2:0][20:0]  vinc_reg;
    logic [2:0]        vneg_reg;
    logic [2:0][22:0]  vn_w;
    logic [2:0][20:0]  vcl_w;
    logic [2:0][20:0]  var_next;
    logic [2:0][20:0]  var_reg;

    // Stage 0: signed distance of each channel from its mean.
    always_comb begin
        logic [16:0] dr;
        logic [16:0] dn;
        s0_carry.px   = in_px;
        s0_carry.mean = in_mean;
        s0_carry.vari = in_var;
        for (int c = 0; c < 3; c++) begin
            dr = {1'b0, in_px[c], 8'd0} - {1'b0, in_mean[c]};
            dn = 17'd0 - dr;
            s0_carry.dneg[c] = dr[16];
            s0_carry.dmag[c] = dr[16] ? dn[15:0] : dr[15:0];
            sq1_next[c] = s0_carry.dmag[c] * s0_carry.dmag[c];
            v1_next[c]  = (in_var[c] == 21'd0) ? 21'd1 : in_var[c];
        end
    end

    // Distance divider: one quotient bit per stage and channel. A quotient
    // of 2^24 or more already exceeds any threshold, so it saturates there.
    always_comb begin
        logic [21:0] t;
        logic [21:0] d;
        logic        ge;
        for (int c = 0; c < 3; c++) begin
            dv_sat_in[DF][c] = {8'd0, sq1_reg[c][31:19]} >= v1_reg[c];
            dv_rem_in[DF][c] = dv_sat_in[DF][c] ? 21'd0 : {8'd0, sq1_reg[c][31:19]};
            dv_quo_in[DF][c] = 24'd0;
            dv_low_in[DF][c] = {sq1_reg[c][18:0], 5'd0};
            dv_v_in[DF][c]   = v1_reg[c];
        end
        for (int k = DF + 1; k <= DL; k++) begin
            dv_rem_in[k] = dv_rem_reg[k-1];
            dv_quo_in[k] = dv_quo_reg[k-1];
            dv_low_in[k] = dv_low_reg[k-1];
            dv_v_in[k]   = dv_v_reg[k-1];
            dv_sat_in[k] = dv_sat_reg[k-1];
        end
        for (int k = DF; k <= DL; k++) begin
            for (int c = 0; c < 3; c++) begin
                t  = {dv_rem_in[k][c], dv_low_in[k][c][DL-k]};
                d  = t - {1'b0, dv_v_in[k][c]};
                ge = t >= {1'b0, dv_v_in[k][c]};
                dv_rem_next[k][c] = ge ? d[20:0] : t[20:0];
                dv_quo_next[k][c] = {dv_quo_in[k][c][22:0], ge};
            end
        end
    end

    always_comb begin
        logic [2:0][24:0] term;
        for (int c = 0; c < 3; c++) begin
            term[c] = dv_sat_reg[DL][c] ? 25'h1000000 : {1'b0, dv_quo_reg[DL][c]};
        end
        sum_next = {2'd0, term[0]} + {2'd0, term[1]} + {2'd0, term[2]};
    end

    // Fuzzy level divider: (d2 * 256) / threshold, 16 quotient bits.
    always_comb begin
        logic [15:0] t;
        logic [15:0] d;
        logic        ge;
        fz_sat_in[FF] = (cfg.dist_thr == 15'd0) ||
                        (sum_reg >= {4'd0, cfg.dist_thr, 8'd0});
        fz_rem_in[FF] = fz_sat_in[FF] ? 15'd0 : sum_reg[22:8];
        fz_quo_in[FF] = 16'd0;
        fz_low_in[FF] = {sum_reg[7:0], 8'd0};
        for (int k = FF + 1; k <= FL; k++) begin
            fz_rem_in[k] = fz_rem_reg[k-1];
            fz_quo_in[k] = fz_quo_reg[k-1];
            fz_low_in[k] = fz_low_reg[k-1];
            fz_sat_in[k] = fz_sat_reg[k-1];
        end
        for (int k = FF; k <= FL; k++) begin
            t  = {fz_rem_in[k], fz_low_in[k][FL-k]};
            d  = t - {1'b0, cfg.dist_thr};
            ge = t >= {1'b0, cfg.dist_thr};
            fz_rem_next[k] = ge ? d[14:0] : t[14:0];
            fz_quo_next[k] = {fz_quo_in[k][14:0], ge};
        end
    end

    // Exponent magnitude, then the table interpolation and scaling.
    always_comb begin
        fuzzy_w = fz_sat_reg[FL] ? 17'h10000 : {1'b0, fz_quo_reg[FL]};
        fg_next = fuzzy_w >= cfg.fg_level;
        nre_w   = cfg.rate_exp[15] ? (16'd0 - cfg.rate_exp) : 16'd0;
        mprod_w = nre_w * fuzzy_w;
        m_next  = (mprod_w[32:16] > 17'd32768) ? 16'h8000 : mprod_w[31:16];

        fa_w    = fgb_pkg::exp_frac({1'b0, m_reg[11:8]});
        fb_w    = fgb_pkg::exp_frac({1'b0, m_reg[11:8]} + 5'd1);
        fdlt_w  = fa_w - fb_w;
        fprod_w = fdlt_w[11:0] * m_reg[7:0];
        ef_next = fa_w - {5'd0, fprod_w[19:8]};
        ei_next = fgb_pkg::exp_int(m_reg[15:12]);

        eprod_w = ei_reg * ef_reg;
        aprod_w = cfg.alpha_max * e_reg;
        alpha_next = (aprod_w[33:16] > 18'd65536) ? 17'h10000 : aprod_w[32:16];
    end

    // Mean step, squared residual and variance step per channel.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            iprod_w[c] = cr_reg[fgb_pkg::ST_ALPHA].dmag[c] * al_reg[fgb_pkg::ST_ALPHA];

            mu18_w[c] = cr_reg[fgb_pkg::ST_MINC].dneg[c]
                ? ({2'd0, cr_reg[fgb_pkg::ST_MINC].mean[c]} - {2'd0, inc_reg[c]})
                : ({2'd0, cr_reg[fgb_pkg::ST_MINC].mean[c]} + {2'd0, inc_reg[c]});
            if (mu18_w[c][17]) begin
                mu_next[c] = 16'd0;
            end else if (mu18_w[c][16]) begin
                mu_next[c] = 16'hFFFF;
            end else begin
                mu_next[c] = mu18_w[c][15:0];
            end

            r17_w[c]  = {1'b0, cr_reg[fgb_pkg::ST_MEAN].px[c], 8'd0}
                        - {1'b0, mu_reg[fgb_pkg::ST_MEAN][c]};
            rneg_w[c] = 17'd0 - r17_w[c];
            rm_w[c]   = r17_w[c][16] ? rneg_w[c][15:0] : r17_w[c][15:0];
            rsq_w[c]  = rm_w[c] * rm_w[c];

            vd_w[c]    = {1'b0, sq_reg[c]} - {1'b0, cr_reg[fgb_pkg::ST_SQ].vari[c]};
            vdn_w[c]   = 22'd0 - vd_w[c];
            vmag_w[c]  = vd_w[c][21] ? vdn_w[c][20:0] : vd_w[c][20:0];
            vprod_w[c] = vmag_w[c] * al_reg[fgb_pkg::ST_SQ];

            vn_w[c] = vneg_reg[c]
                ? ({2'd0, cr_reg[fgb_pkg::ST_VINC].vari[c]} - {2'd0, vinc_reg[c]})
                : ({2'd0, cr_reg[fgb_pkg::ST_VINC].vari[c]} + {2'd0, vinc_reg[c]});
            if (vn_w[c][22]) begin
                vcl_w[c] = 21'd0;
            end else if (vn_w[c][21]) begin
                vcl_w[c] = 21'h1FFFFF;
            end else begin
                vcl_w[c] = vn_w[c][20:0];
            end
            var_next[c] = (vcl_w[c] < {9'd0, cfg.noise_floor}) ?
                          {9'd0, cfg.noise_floor} : vcl_w[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq1_reg   <= sq1_next;
            v1_reg    <= v1_next;
            cr_reg[1] <= s0_carry;
            for (int k = 2; k <= LAT; k++) begin
                cr_reg[k] <= cr_reg[k-1];
            end
            for (int k = DF; k <= DL; k++) begin
                dv_rem_reg[k] <= dv_rem_next[k];
                dv_quo_reg[k] <= dv_quo_next[k];
                dv_low_reg[k] <= dv_low_in[k];
                dv_v_reg[k]   <= dv_v_in[k];
                dv_sat_reg[k] <= dv_sat_in[k];
            end
            sum_reg <= sum_next;
            for (int k = FF; k <= FL; k++) begin
                fz_rem_reg[k] <= fz_rem_next[k];
                fz_quo_reg[k] <= fz_quo_next[k];
                fz_low_reg[k] <= fz_low_in[k];
                fz_sat_reg[k] <= fz_sat_in[k];
            end
            m_reg  <= m_next;
            fg_reg[fgb_pkg::ST_RATE] <= fg_next;
            for (int k = fgb_pkg::ST_RATE + 1; k <= LAT; k++) begin
                fg_reg[k] <= fg_reg[k-1];
            end
            ef_reg <= ef_next;
            ei_reg <= ei_next;
            e_reg  <= eprod_w[32:16];
            al_reg[fgb_pkg::ST_ALPHA] <= alpha_next;
            for (int k = fgb_pkg::ST_ALPHA + 1; k <= fgb_pkg::ST_SQ; k++) begin
                al_reg[k] <= al_reg[k-1];
            end
            for (int c = 0; c < 3; c++) begin
                inc_reg[c]  <= iprod_w[c][31:16];
                sq_reg[c]   <= rsq_w[c][31:11];
                vinc_reg[c] <= vprod_w[c][36:16];
                vneg_reg[c] <= vd_w[c][21];
            end
            mu_reg[fgb_pkg::ST_MEAN] <= mu_next;
            for (int k = fgb_pkg::ST_MEAN + 1; k <= LAT; k++) begin
                mu_reg[k] <= mu_reg[k-1];
            end
            var_reg <= var_next;
        end
    end

    assign out_mean = mu_reg[LAT];
    assign out_var  = var_reg;
    assign out_fg   = fg_reg[LAT];

endmodule

`default_nettype wire

>>> src/fuzzy_gauss_background_pixel_top.sv
// ----------------------------------------------------------------------------
// fuzzy_gauss_background_pixel_top
// Per-pixel fuzzy Gaussian background model: classifies each pixel and
// updates its stored mean and variance.
// ----------------------------------------------------------------------------
// Channel   Direction  Ports                         Moves
// input     in         s_tvalid/s_tready/s_tdata/u   one pixel request per item
// result    out        m_tvalid/m_tready/m_tdata/u   one classification per item
// config    in         cfg_we/cfg_index/cfg_wdata    one register write per cycle
//
// One item is taken per cycle unless a stalled result or the interlock holds it.
// The model lives in two memories read at accept and written back from the
// last stage; an item whose pixel is still in flight waits until it is written.
// After reset a clearing pass loads every entry in address order; no item
// is taken meanwhile. A stalled result holds the whole pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fuzzy_gauss_background_pixel_top #(
    parameter int NUM_PIXELS = fgb_pkg::NUM_PIXELS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pixel_index[16:0], in_red[24:17], in_green[32:25], in_blue[40:33]
    input  wire logic [47:0]  s_tdata,
    // req_type[0]
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_index[16:0], bg_red[24:17], bg_green[32:25], bg_blue[40:33]
    output logic [47:0]       m_tdata,
    // is_foreground[0]
    output logic              m_tuser,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [16:0]  cfg_wdata
);

    `include "assert_macros.svh"

    localparam int AW  = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int LAT = fgb_pkg::LAT;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PIXELS - 1);

    fgb_pkg::cfg_t    cfg_reg;
    fgb_pkg::pipe_t   s_item;
    fgb_pkg::pipe_t   pipe_reg [0:LAT];
    logic [LAT:0]     vld_reg;
    logic             in_range;
    logic             hit;
    logic             adv;
    logic             acc_ok;

    logic             clr_busy_reg;
    logic [AW-1:0]    clr_addr_reg;

    logic [47:0]      mean_mem [NUM_PIXELS];
    logic [62:0]      var_mem  [NUM_PIXELS];
    logic [47:0]      rd_mean_reg;
    logic [62:0]      rd_var_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [47:0]      mem_wmean;
    logic [62:0]      mem_wvar;

    logic [2:0][15:0] dp_mean;
    logic [2:0][20:0] dp_var;
    logic             dp_fg;

    logic             m_valid_reg;
    logic [16:0]      m_idx_reg;
    logic [2:0][7:0]  m_bg_reg;
    logic             m_fg_reg;

    assign s_item.init  = s_tuser;
    assign s_item.idx   = s_tdata[16:0];
    assign s_item.px[0] = s_tdata[24:17];
    assign s_item.px[1] = s_tdata[32:25];
    assign s_item.px[2] = s_tdata[40:33];

    assign in_range = 32'(s_item.idx) < NUM_PIXELS;
    assign adv      = !m_valid_reg || m_tready;

    // Interlock: a pixel whose model is between read and write-back blocks
    // a new item for the same pixel.
    always_comb begin
        hit = 1'b0;
        for (int k = 0; k <= LAT; k++) begin
            if (vld_reg[k] && (pipe_reg[k].idx == s_item.idx)) begin
                hit = 1'b1;
            end
        end
    end

    assign s_tready = adv && !clr_busy_reg && !hit;
    assign acc_ok   = s_tvalid && s_tready && in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dist_thr    <= fgb_pkg::DIST_THR_RST;
            cfg_reg.fg_level    <= fgb_pkg::FG_LEVEL_RST;
            cfg_reg.alpha_max   <= fgb_pkg::ALPHA_MAX_RST;
            cfg_reg.noise_floor <= fgb_pkg::NOISE_RST;
            cfg_reg.rate_exp    <= fgb_pkg::RATE_EXP_RST;
            vld_reg      <= '0;
            m_valid_reg  <= 1'b0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    fgb_pkg::REG_DIST_THR:  cfg_reg.dist_thr    <= cfg_wdata[14:0];
                    fgb_pkg::REG_FG_LEVEL:  cfg_reg.fg_level    <= cfg_wdata;
                    fgb_pkg::REG_ALPHA_MAX: cfg_reg.alpha_max   <= cfg_wdata;
                    fgb_pkg::REG_NOISE:     cfg_reg.noise_floor <= cfg_wdata[11:0];
                    fgb_pkg::REG_RATE_EXP:  cfg_reg.rate_exp    <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (adv) begin
                vld_reg     <= {vld_reg[LAT-1:0], acc_ok};
                m_valid_reg <= vld_reg[LAT] && !pipe_reg[LAT].init;
            end
            if (clr_busy_reg) begin
                if (clr_addr_reg == LAST_ADDR) begin
                    clr_busy_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pipe_reg[0] <= s_item;
            for (int k = 1; k <= LAT; k++) begin
                pipe_reg[k] <= pipe_reg[k-1];
            end
            m_idx_reg <= pipe_reg[LAT].idx;
            m_fg_reg  <= dp_fg;
            for (int c = 0; c < 3; c++) begin
                m_bg_reg[c] <= dp_mean[c][15:8];
            end
        end
    end

    // Write-back of the last stage, or the clearing pass after reset.
    always_comb begin
        mem_we = clr_busy_reg || (adv && vld_reg[LAT]);
        if (clr_busy_reg) begin
            mem_waddr = clr_addr_reg;
            mem_wmean = 48'd0;
            mem_wvar  = {3{fgb_pkg::VAR_RESET}};
        end else if (pipe_reg[LAT].init) begin
            mem_waddr = AW'(pipe_reg[LAT].idx);
            mem_wmean = {pipe_reg[LAT].px[2], 8'd0, pipe_reg[LAT].px[1], 8'd0,
                         pipe_reg[LAT].px[0], 8'd0};
            mem_wvar  = {3{9'd0, cfg_reg.noise_floor}};
        end else begin
            mem_waddr = AW'(pipe_reg[LAT].idx);
            mem_wmean = dp_mean;
            mem_wvar  = dp_var;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mean_mem[mem_waddr] <= mem_wmean;
            var_mem[mem_waddr]  <= mem_wvar;
        end
        if (adv) begin
            rd_mean_reg <= mean_mem[AW'(s_item.idx)];
            rd_var_reg  <= var_mem[AW'(s_item.idx)];
        end
    end

    fgb_datapath u_datapath (
        .aclk     (aclk),
        .adv      (adv),
        .cfg      (cfg_reg),
        .in_px    (pipe_reg[0].px),
        .in_mean  (rd_mean_reg),
        .in_var   (rd_var_reg),
        .out_mean (dp_mean),
        .out_var  (dp_var),
        .out_fg   (dp_fg)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_bg_reg[2], m_bg_reg[1], m_bg_reg[0], m_idx_reg};
    assign m_tuser  = m_fg_reg;

    `FGB_ASSERT_ALWAYS(a_no_take_in_clear, aclk, clr_busy_reg |-> !s_tready, "item taken during clearing pass")
    `FGB_ASSERT(a_empty_in_clear, aclk, aresetn, clr_busy_reg |-> (vld_reg == '0), "pipeline busy during clearing pass")
    `FGB_ASSERT(a_stall_holds, aclk, aresetn, (m_valid_reg && !m_tready) |=> $stable(vld_reg), "pipeline moved while result stalled")
    `FGB_ASSERT(a_result_source, aclk, aresetn, $rose(m_valid_reg) |-> $past(vld_reg[LAT] && !pipe_reg[LAT].init), "result without an update item")

endmodule

`default_nettype wire
